// ===== rtl/core/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg: shared definitions for the integer matrix multiplier
// Sizes of the element stores, operation codes, register indexes and the walk pipeline tag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imm_pkg;

  // matrix and element sizes
  localparam int unsigned MaxDim    = 8;
  localparam int unsigned ElemWidth = 16;
  localparam int unsigned IdxW      = $clog2(MaxDim);
  localparam int unsigned AddrW     = 2 * IdxW;
  localparam int unsigned DimW      = IdxW + 1;
  localparam int unsigned ProdW     = 35;
  localparam int unsigned MulW      = 2 * ElemWidth;
  localparam int unsigned Depth     = MaxDim * MaxDim;

  // configuration port
  localparam int unsigned PAddrW = 4;
  localparam int unsigned PDataW = 32;

  // request operation codes
  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_e;

  // tag carried with each multiply-accumulate step
  typedef struct packed {
    logic            first_k;
    logic            last_k;
    logic            last_elem;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } tag_t;

  // clamp a written dimension into 1..MaxDim
  function automatic logic [DimW-1:0] clamp_dim(input logic [3:0] raw);
    logic [DimW-1:0] res;
    if (raw == 4'd0) begin
      res = DimW'(1);
    end else if (raw > 4'(MaxDim)) begin
      res = DimW'(MaxDim);
    end else begin
      res = DimW'(raw);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/integer_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply: signed matrix product over two element stores
// A load request writes one element; loads are taken every cycle while idle.
// A compute request walks rows_a*cols_b*inner_dim multiply-accumulate steps,
// one per cycle (one read port per store), through a registered read, a
// multiply and an accumulate; busy_o drops with the last result. Results are
// strobed for one cycle each and the receiver cannot stall. Reset sets every
// dimension to 8; stores stay undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_matrix_multiply (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // configuration port
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [imm_pkg::PAddrW-1:0]                  paddr,
  input  logic [imm_pkg::PDataW-1:0]                  pwdata,
  output logic [imm_pkg::PDataW-1:0]                  prdata,
  output logic                                        pready,
  // request channel
  input  logic                                        start_i,
  output logic                                        busy_o,
  input  logic [1:0]                                  op_i,
  input  logic [imm_pkg::IdxW-1:0]                    row_index_i,
  input  logic [imm_pkg::IdxW-1:0]                    col_index_i,
  input  logic signed [imm_pkg::ElemWidth-1:0]        elem_value_i,
  // result channel
  output logic                                        result_valid_o,
  output logic [imm_pkg::IdxW-1:0]                    out_row_o,
  output logic [imm_pkg::IdxW-1:0]                    out_col_o,
  output logic signed [imm_pkg::ProdW-1:0]            product_value_o,
  output logic                                        last_flag_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [imm_pkg::DimW-1:0] rows_a_q, inner_dim_q, cols_b_q;

  // configuration writes and reads
  logic       cfg_we;
  imm_pkg::reg_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = imm_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= imm_pkg::DimW'(imm_pkg::MaxDim);
      inner_dim_q <= imm_pkg::DimW'(imm_pkg::MaxDim);
      cols_b_q    <= imm_pkg::DimW'(imm_pkg::MaxDim);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        imm_pkg::REG_ROWS_A:    rows_a_q    <= imm_pkg::clamp_dim(pwdata[3:0]);
        imm_pkg::REG_INNER_DIM: inner_dim_q <= imm_pkg::clamp_dim(pwdata[3:0]);
        imm_pkg::REG_COLS_B:    cols_b_q    <= imm_pkg::clamp_dim(pwdata[3:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      imm_pkg::REG_ROWS_A:    prdata = imm_pkg::PDataW'(rows_a_q);
      imm_pkg::REG_INNER_DIM: prdata = imm_pkg::PDataW'(inner_dim_q);
      imm_pkg::REG_COLS_B:    prdata = imm_pkg::PDataW'(cols_b_q);
      default:                prdata = '0;
    endcase
  end

  // request decode
  logic       req_acc;
  imm_pkg::op_e req_op;
  logic       we_a, we_b, compute_go;

  assign busy_o     = (state_q != ST_IDLE);
  assign req_acc    = start_i & ~busy_o;
  assign req_op     = imm_pkg::op_e'(op_i);
  assign we_a       = req_acc && (req_op == imm_pkg::OP_LOAD_A)
                      && ({1'b0, row_index_i} < rows_a_q)
                      && ({1'b0, col_index_i} < inner_dim_q);
  assign we_b       = req_acc && (req_op == imm_pkg::OP_LOAD_B)
                      && ({1'b0, row_index_i} < inner_dim_q)
                      && ({1'b0, col_index_i} < cols_b_q);
  assign compute_go = req_acc && (req_op == imm_pkg::OP_COMPUTE);

  // walk counters: k innermost, then column, then row
  logic [imm_pkg::IdxW-1:0] i_q, j_q, k_q;
  logic last_i, last_j, last_k, walking;

  assign walking = (state_q == ST_WALK);
  assign last_i  = ({1'b0, i_q} == rows_a_q - imm_pkg::DimW'(1));
  assign last_j  = ({1'b0, j_q} == cols_b_q - imm_pkg::DimW'(1));
  assign last_k  = ({1'b0, k_q} == inner_dim_q - imm_pkg::DimW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (compute_go) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (walking) begin
      if (!last_k) begin
        k_q <= k_q + imm_pkg::IdxW'(1);
      end else begin
        k_q <= '0;
        if (!last_j) begin
          j_q <= j_q + imm_pkg::IdxW'(1);
        end else begin
          j_q <= '0;
          i_q <= i_q + imm_pkg::IdxW'(1);
        end
      end
    end
  end

  // store addresses
  logic [imm_pkg::AddrW-1:0] wr_addr, rd_addr_a, rd_addr_b;

  assign wr_addr   = {row_index_i, col_index_i};
  assign rd_addr_a = {i_q, k_q};
  assign rd_addr_b = {k_q, j_q};

  // element stores, one write and one registered read port each
  logic signed [imm_pkg::ElemWidth-1:0] store_a [imm_pkg::Depth];
  logic signed [imm_pkg::ElemWidth-1:0] store_b [imm_pkg::Depth];
  logic signed [imm_pkg::ElemWidth-1:0] a_rd_q, b_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      store_a[wr_addr] <= elem_value_i;
    end
    a_rd_q <= store_a[rd_addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      store_b[wr_addr] <= elem_value_i;
    end
    b_rd_q <= store_b[rd_addr_b];
  end

  // pipeline: read, multiply, accumulate
  imm_pkg::tag_t issue_tag, s1_tag_q, s2_tag_q;
  logic s1_valid_q, s2_valid_q;
  logic signed [imm_pkg::MulW-1:0]  prod_q;
  logic signed [imm_pkg::ProdW-1:0] acc_q, acc_base, acc_sum;

  always_comb begin
    issue_tag.first_k   = (k_q == '0);
    issue_tag.last_k    = last_k;
    issue_tag.last_elem = last_i & last_j;
    issue_tag.row       = i_q;
    issue_tag.col       = j_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= walking;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= issue_tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= a_rd_q * b_rd_q;
  end

  // wrap-around accumulation, exact modulo the result width
  assign acc_base = s2_tag_q.first_k ? '0 : acc_q;
  assign acc_sum  = acc_base + imm_pkg::ProdW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      acc_q <= acc_sum;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= s2_valid_q & s2_tag_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s2_tag_q.last_k) begin
      out_row_o       <= s2_tag_q.row;
      out_col_o       <= s2_tag_q.col;
      product_value_o <= acc_sum;
      last_flag_o     <= s2_tag_q.last_elem;
    end
  end

  // control sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (compute_go) state_d = ST_WALK;
      ST_WALK:  if (last_i && last_j && last_k) state_d = ST_DRAIN;
      ST_DRAIN: if (s2_valid_q && s2_tag_q.last_k && s2_tag_q.last_elem) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  // stores are only written between runs
  a_store_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_a || we_b) |-> (state_q == ST_IDLE))
    else $error("store written during a compute run");

  // pipeline is empty whenever the block is free
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_valid_q && !s2_valid_q))
    else $error("walk pipeline busy while idle");

  // the flagged result closes its run
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_flag_o) |=> !result_valid_o)
    else $error("result follows the last flagged result");

  // a result only ever follows a walk
  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(s2_valid_q))
    else $error("result without a completed accumulation");
`endif

endmodule

// ===== bench/integer_matrix_multiply_tb.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_tb: self-checking bench for the matrix multiplier
// Loads A and B elements, issues compute requests and checks every product
// element. The expected products come from a bench-side model of the
// stores and dimensions. Dimensions are changed over the APB port between
// phases, once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_matrix_multiply_tb;

  localparam int CycleLimit = 400000;
  localparam int ItemTarget = 370;

  // one request as presented on the request channel
  typedef struct {
    imm_pkg::op_e                 op;
    logic [imm_pkg::IdxW-1:0]     row;
    logic [imm_pkg::IdxW-1:0]     col;
    logic signed [15:0]           val;
  } req_t;

  // one product element as it should leave the block
  typedef struct {
    logic [imm_pkg::IdxW-1:0]           row;
    logic [imm_pkg::IdxW-1:0]           col;
    logic signed [imm_pkg::ProdW-1:0]   value;
    logic                               last;
  } product_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [imm_pkg::PAddrW-1:0]       paddr = '0;
  logic [imm_pkg::PDataW-1:0]       pwdata = '0;
  logic [imm_pkg::PDataW-1:0]       prdata;
  logic                             pready;

  logic                             start_i = 1'b0;
  logic                             busy_o;
  logic [1:0]                       op_i = imm_pkg::OP_NONE;
  logic [imm_pkg::IdxW-1:0]         row_index_i = '0;
  logic [imm_pkg::IdxW-1:0]         col_index_i = '0;
  logic signed [15:0]               elem_value_i = '0;

  logic                             result_valid_o;
  logic [imm_pkg::IdxW-1:0]         out_row_o;
  logic [imm_pkg::IdxW-1:0]         out_col_o;
  logic signed [imm_pkg::ProdW-1:0] product_value_o;
  logic                             last_flag_o;

  integer_matrix_multiply dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .elem_value_i   (elem_value_i),
    .result_valid_o (result_valid_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .product_value_o(product_value_o),
    .last_flag_o    (last_flag_o)
  );

  // bench copy of the stores and dimensions
  logic signed [15:0] mat_a [imm_pkg::Depth];
  logic signed [15:0] mat_b [imm_pkg::Depth];
  int dim_rows  = 8;
  int dim_inner = 8;
  int dim_cols  = 8;

  // entries the stimulus has already loaded, so no compute reads garbage
  bit loaded_a [imm_pkg::Depth];
  bit loaded_b [imm_pkg::Depth];

  req_t     pend_q[$];
  product_t product_q[$];

  bit req_accepted = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int n_issued = 0;
  int n_accepted = 0;
  int n_effective = 0;
  int n_computes = 0;
  int n_products_seen = 0;
  int n_phases = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int sat_dim(logic [3:0] raw);
    if (raw == 4'd0) begin
      return 1;
    end else if (raw > 4'(imm_pkg::MaxDim)) begin
      return imm_pkg::MaxDim;
    end
    return int'(raw);
  endfunction

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return ($urandom_range(0, 1) == 0) ? 16'sh0000 : 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // update the store model for a request and queue any product elements
  task automatic apply_request(imm_pkg::op_e op, logic [imm_pkg::IdxW-1:0] r,
                               logic [imm_pkg::IdxW-1:0] c, logic signed [15:0] v);
    product_t p;
    logic signed [63:0] acc;
    case (op)
      imm_pkg::OP_LOAD_A: begin
        if (r < dim_rows && c < dim_inner) mat_a[r * imm_pkg::MaxDim + c] = v;
      end
      imm_pkg::OP_LOAD_B: begin
        if (r < dim_inner && c < dim_cols) mat_b[r * imm_pkg::MaxDim + c] = v;
      end
      imm_pkg::OP_COMPUTE: begin
        n_computes++;
        for (int i = 0; i < dim_rows; i++) begin
          for (int j = 0; j < dim_cols; j++) begin
            acc = '0;
            for (int k = 0; k < dim_inner; k++) begin
              acc += 64'(mat_a[i * imm_pkg::MaxDim + k]) *
                     64'(mat_b[k * imm_pkg::MaxDim + j]);
            end
            p.row   = imm_pkg::IdxW'(i);
            p.col   = imm_pkg::IdxW'(j);
            p.value = acc[imm_pkg::ProdW-1:0];
            p.last  = (i == dim_rows - 1) && (j == dim_cols - 1);
            product_q.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endtask

  // queue a request and note which store entries it fills
  task automatic push_req(imm_pkg::op_e op, int r, int c, logic signed [15:0] v);
    req_t q;
    q.op  = op;
    q.row = imm_pkg::IdxW'(r);
    q.col = imm_pkg::IdxW'(c);
    q.val = v;
    if (op == imm_pkg::OP_LOAD_A && r < dim_rows && c < dim_inner) begin
      loaded_a[r * imm_pkg::MaxDim + c] = 1'b1;
      n_effective++;
    end else if (op == imm_pkg::OP_LOAD_B && r < dim_inner && c < dim_cols) begin
      loaded_b[r * imm_pkg::MaxDim + c] = 1'b1;
      n_effective++;
    end else if (op == imm_pkg::OP_COMPUTE) begin
      n_effective++;
    end
    pend_q.push_back(q);
  endtask

  // request that the block must ignore
  task automatic push_noise();
    int sel;
    sel = $urandom_range(0, 2);
    if (sel == 0 && dim_rows < imm_pkg::MaxDim) begin
      push_req(imm_pkg::OP_LOAD_A, $urandom_range(dim_rows, 7), $urandom_range(0, 7),
               rand_elem());
    end else if (sel == 0 && dim_inner < imm_pkg::MaxDim) begin
      push_req(imm_pkg::OP_LOAD_A, $urandom_range(0, 7), $urandom_range(dim_inner, 7),
               rand_elem());
    end else if (sel == 1 && dim_inner < imm_pkg::MaxDim) begin
      push_req(imm_pkg::OP_LOAD_B, $urandom_range(dim_inner, 7), $urandom_range(0, 7),
               rand_elem());
    end else if (sel == 1 && dim_cols < imm_pkg::MaxDim) begin
      push_req(imm_pkg::OP_LOAD_B, $urandom_range(0, 7), $urandom_range(dim_cols, 7),
               rand_elem());
    end else begin
      push_req(imm_pkg::OP_NONE, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
    end
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(imm_pkg::reg_e idx, logic [3:0] raw);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= imm_pkg::PAddrW'({idx, 2'b00});
    pwdata  <= {28'($urandom), raw};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      imm_pkg::REG_ROWS_A:    dim_rows  = sat_dim(raw);
      imm_pkg::REG_INNER_DIM: dim_inner = sat_dim(raw);
      imm_pkg::REG_COLS_B:    dim_cols  = sat_dim(raw);
      default: ;
    endcase
  endtask

  // hold until every request is taken and every product has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || n_accepted != n_issued || product_q.size() != 0 || busy_o);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [3:0] pick_dim_raw();
    case ($urandom_range(0, 19))
      0: return 4'd0;
      1: return 4'(imm_pkg::MaxDim);
      2: return 4'($urandom_range(9, 15));
      3, 4: return 4'($urandom_range(4, 7));
      default: return 4'($urandom_range(1, 3));
    endcase
  endfunction

  // one random phase: fill the operands in shuffled order, compute, then up to two rounds of tweak and compute
  task automatic plan_phase();
    req_t batch[$];
    req_t tmp;
    int j;
    for (int r = 0; r < dim_rows; r++) begin
      for (int c = 0; c < dim_inner; c++) begin
        if (!loaded_a[r * imm_pkg::MaxDim + c] || $urandom_range(0, 2) == 0) begin
          tmp.op = imm_pkg::OP_LOAD_A; tmp.row = imm_pkg::IdxW'(r);
          tmp.col = imm_pkg::IdxW'(c); tmp.val = rand_elem();
          batch.push_back(tmp);
        end
      end
    end
    for (int r = 0; r < dim_inner; r++) begin
      for (int c = 0; c < dim_cols; c++) begin
        if (!loaded_b[r * imm_pkg::MaxDim + c] || $urandom_range(0, 2) == 0) begin
          tmp.op = imm_pkg::OP_LOAD_B; tmp.row = imm_pkg::IdxW'(r);
          tmp.col = imm_pkg::IdxW'(c); tmp.val = rand_elem();
          batch.push_back(tmp);
        end
      end
    end
    for (int i = batch.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = batch[i];
      batch[i] = batch[j];
      batch[j] = tmp;
    end
    foreach (batch[i]) begin
      if ($urandom_range(0, 9) == 0) push_noise();
      push_req(batch[i].op, batch[i].row, batch[i].col, batch[i].val);
    end
    push_req(imm_pkg::OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1) == 0) begin
          push_req(imm_pkg::OP_LOAD_A, $urandom_range(0, dim_rows - 1),
                   $urandom_range(0, dim_inner - 1), rand_elem());
        end else begin
          push_req(imm_pkg::OP_LOAD_B, $urandom_range(0, dim_inner - 1),
                   $urandom_range(0, dim_cols - 1), rand_elem());
        end
      end
      if ($urandom_range(0, 2) == 0) push_noise();
      push_req(imm_pkg::OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
               rand_elem());
    end
  endtask

  // request driver: bursts with random gaps, one request held until taken
  always @(negedge clk_i) begin : req_driver
    req_t cur;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || req_accepted) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (pend_q.size() != 0) begin
        cur = pend_q.pop_front();
        op_i         <= cur.op;
        row_index_i  <= cur.row;
        col_index_i  <= cur.col;
        elem_value_i <= cur.val;
        start_i      <= 1'b1;
        // counted at once so an idle check in this step sees the request
        n_issued++;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // request acceptance, prediction and run limit
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_accepted <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      req_accepted <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        apply_request(imm_pkg::op_e'(op_i), row_index_i, col_index_i, elem_value_i);
        n_accepted <= n_accepted + 1;
      end
      if (cycle_cnt >= CycleLimit) begin
        $display("%0t: run limit of %0d cycles reached", $time, CycleLimit);
        $display("FAIL integer_matrix_multiply");
        $finish;
      end
    end
  end

  function automatic bit field_bad(string name, logic signed [63:0] want,
                                   logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // product monitor: compare each strobed element with the oldest expectation
  always @(posedge clk_i) begin : product_monitor
    product_t want;
    bit bad;
    if (rst_ni && result_valid_o) begin
      n_products_seen++;
      if (product_q.size() == 0) begin
        $display("%0t: unexpected product, expected none, got row %0d col %0d value %0d",
                 $time, out_row_o, out_col_o, product_value_o);
        err_cnt++;
      end else begin
        want = product_q.pop_front();
        bad  = field_bad("out_row", 64'(want.row), 64'(out_row_o));
        bad |= field_bad("out_col", 64'(want.col), 64'(out_col_o));
        bad |= field_bad("product_value", 64'(want.value), 64'(product_value_o));
        bad |= field_bad("last_flag", 64'(want.last), 64'(last_flag_o));
        if (bad) err_cnt++;
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: one row by one column, inner length 8, saturating writes
    write_reg(imm_pkg::REG_ROWS_A, 4'd0);
    write_reg(imm_pkg::REG_INNER_DIM, 4'd8);
    write_reg(imm_pkg::REG_COLS_B, 4'd1);
    for (int k = 0; k < imm_pkg::MaxDim; k++) push_req(imm_pkg::OP_LOAD_A, 0, k, 16'sh8000);
    for (int k = 0; k < imm_pkg::MaxDim; k++) push_req(imm_pkg::OP_LOAD_B, k, 0, 16'sh8000);
    // loads outside the dimensions and the unused op code are dropped
    push_req(imm_pkg::OP_LOAD_A, 7, 7, 16'sh1234);
    push_req(imm_pkg::OP_LOAD_B, 3, 5, 16'sh5a5a);
    push_req(imm_pkg::OP_NONE, 7, 7, 16'shffff);
    push_req(imm_pkg::OP_COMPUTE, 0, 0, 16'sh0000);
    push_req(imm_pkg::OP_LOAD_A, 0, 0, 16'sh7fff);
    push_req(imm_pkg::OP_LOAD_B, 7, 0, 16'sh7fff);
    push_req(imm_pkg::OP_COMPUTE, 7, 7, 16'shffff);
    n_phases++;

    // random phases, each started from an idle block
    while (n_effective < ItemTarget) begin
      wait_idle();
      write_reg(imm_pkg::REG_ROWS_A, pick_dim_raw());
      write_reg(imm_pkg::REG_INNER_DIM, pick_dim_raw());
      write_reg(imm_pkg::REG_COLS_B, pick_dim_raw());
      plan_phase();
      n_phases++;
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (product_q.size() != 0) begin
      $display("%0t: %0d product elements never arrived, expected row %0d col %0d",
               $time, product_q.size(), product_q[0].row, product_q[0].col);
      err_cnt++;
    end
    $display("covered %0d phases, %0d requests taken, %0d computes", n_phases, n_accepted,
             n_computes);
    $display("checked %0d product elements, %0d mismatches", n_products_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS integer_matrix_multiply");
    end else begin
      $display("FAIL integer_matrix_multiply");
    end
    $finish;
  end

endmodule
